// ----- rtl/core/error_diffusion_dither_core_defines.svh -----
// Assertion macros shared by the error diffusion dither RTL.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef ERROR_DIFFUSION_DITHER_CORE_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EDD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/edd_pkg.sv -----
// Shared constants and types for the error diffusion dither core.
// No dependencies; used by edd_pix_if, the lane and the top level.
package edd_pkg;

  localparam int NUM_CH      = 3;
  localparam int PIX_W       = 8;
  localparam int LEN_W       = 11;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SHARE_SHIFT = 4;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  // Register index, taken from paddr[2].
  localparam logic [0:0] REG_LINE_LENGTH = 1'b0;

  typedef struct packed {
    logic fire;
    logic frame_start;
    logic last;
  } lane_ctl_t;

endpackage

// ----- rtl/core/edd_pix_if.sv -----
// Input channel carrying one RGB pixel item with its frame start flag.
// Depends on edd_pkg for the pixel width.
interface edd_pix_if;
  logic                     valid;
  logic                     ready;
  logic [edd_pkg::PIX_W-1:0] red_in;
  logic [edd_pkg::PIX_W-1:0] green_in;
  logic [edd_pkg::PIX_W-1:0] blue_in;
  logic                     frame_start;

  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

// ----- rtl/core/edd_bit_if.sv -----
// Result channel carrying the three dithered bits and the line end flag.
// No dependencies.
interface edd_bit_if;
  logic valid;
  logic ready;
  logic red_bit;
  logic green_bit;
  logic blue_bit;
  logic line_end;

  modport source (output valid, red_bit, green_bit, blue_bit, line_end, input ready);
  modport sink   (input valid, red_bit, green_bit, blue_bit, line_end, output ready);
endinterface

// ----- rtl/core/edd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module edd_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/edd_lane.sv -----
// One color channel of the dither: threshold, error split and the
// per-channel carry registers. Depends on edd_pkg.
module edd_lane #(
  parameter int FRAC_BITS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  edd_pkg::lane_ctl_t                   ctl,
  input  logic [edd_pkg::PIX_W-1:0]            value,
  input  logic signed [FRAC_BITS+9:0]          mem_err,
  output logic                                 bit_o,
  output logic signed [FRAC_BITS+9:0]          left_err,
  output logic signed [FRAC_BITS+9:0]          here_err
);

  localparam int ERR_W = FRAC_BITS + 10;
  localparam int P_W   = ERR_W + 3;

  localparam logic signed [ERR_W:0] EXT_HI = (ERR_W+1)'((1 << (ERR_W - 1)) - 1);
  localparam logic signed [ERR_W:0] EXT_LO = ~EXT_HI;
  localparam logic signed [ERR_W:0] HALF   = (ERR_W+1)'(255 << (FRAC_BITS - 1));
  localparam logic signed [ERR_W:0] FULL   = (ERR_W+1)'(255 << FRAC_BITS);

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ERR_W:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > EXT_HI) begin
      r = EXT_HI[ERR_W-1:0];
    end else if (v < EXT_LO) begin
      r = EXT_LO[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

  logic signed [ERR_W-1:0] right_carry_r, right_carry_nxt;
  logic signed [ERR_W-1:0] below_left_r, below_left_nxt;
  logic signed [ERR_W-1:0] below_r, below_nxt;

  logic signed [ERR_W-1:0] carry, bl, bp, err, e;
  logic signed [ERR_W:0]   v_scaled, sum, e_raw;
  logic signed [P_W-1:0]   ex, e3, e5, e7;
  logic signed [ERR_W-1:0] s1, s3, s5, s7;

  always_comb begin
    carry    = ctl.frame_start ? '0 : right_carry_r;
    bl       = ctl.frame_start ? '0 : below_left_r;
    bp       = ctl.frame_start ? '0 : below_r;
    err      = sat_err((ERR_W+1)'(carry) + (ERR_W+1)'(mem_err));
    v_scaled = signed'((ERR_W+1)'({value, {FRAC_BITS{1'b0}}}));
    sum      = v_scaled + (ERR_W+1)'(err);
    bit_o    = sum > HALF;
    e_raw    = sum - (bit_o ? FULL : '0);
    e        = sat_err(e_raw);
    // Weights 3 and 5 as shift-and-add and 7 as shift-and-subtract, then floor by the shift.
    ex       = P_W'(e);
    e3       = (ex <<< 1) + ex;
    e5       = (ex <<< 2) + ex;
    e7       = (ex <<< 3) - ex;
    s1       = ERR_W'(ex >>> edd_pkg::SHARE_SHIFT);
    s3       = ERR_W'(e3 >>> edd_pkg::SHARE_SHIFT);
    s5       = ERR_W'(e5 >>> edd_pkg::SHARE_SHIFT);
    s7       = ERR_W'(e7 >>> edd_pkg::SHARE_SHIFT);
    here_err = sat_err((ERR_W+1)'(bp) + (ERR_W+1)'(s5));
    left_err = sat_err((ERR_W+1)'(bl) + (ERR_W+1)'(s3));

    right_carry_nxt = right_carry_r;
    below_left_nxt  = below_left_r;
    below_nxt       = below_r;
    if (ctl.fire) begin
      if (ctl.last) begin
        right_carry_nxt = '0;
        below_left_nxt  = '0;
        below_nxt       = '0;
      end else begin
        right_carry_nxt = s7;
        below_left_nxt  = here_err;
        below_nxt       = s1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_carry_r <= '0;
      below_left_r  <= '0;
      below_r       <= '0;
    end else begin
      right_carry_r <= right_carry_nxt;
      below_left_r  <= below_left_nxt;
      below_r       <= below_nxt;
    end
  end

endmodule

// ----- rtl/core/error_diffusion_dither_core.sv -----
// Error diffusion dither core: three color lanes, the line error store
// and the APB register. Depends on edd_pkg, edd_pix_if, edd_bit_if, edd_ram,
// edd_lane and error_diffusion_dither_core_defines.svh.
//
// Floyd-Steinberg dither for an RGB pixel stream in scan order. Each item is
// one pixel (8 bits per channel plus a frame start flag) and yields one result
// item with one bit per channel and a line end flag. The core accepts one item
// per clock for as long as the result channel takes one item per clock. A
// result moves from the compute stage register into the output register
// and waits there until it is taken. A result that waits at the output holds
// the compute stage, and that in turn holds off the input. The rate is set by
// the pixel-to-pixel error carry, which each lane closes through a single
// carry register, the only register in that loop: the
// 7/16 share of one pixel feeds the threshold of the next. The three channels
// run as parallel lanes on the same pixel, and the top level merges their
// errors into one word of the line error store, a LINE_MAX-deep RAM with one
// write port and a registered read port. The read for a pixel is issued at the
// clock that accepts it, and a small bypass register covers a write to the
// same entry at that clock or while the pixel waits. A frame start needs no
// clearing pass: a fill count marks how many entries of the store have been
// written in the current frame, and entries beyond it read as zero. The last
// pixel of a line writes two entries; the second write is held in a register
// and lands in the slot of the first pixel of the next line, which writes none.
// Register line_length (address 0) sets the pixels per line; values below 2
// act as 2 and values above LINE_MAX as LINE_MAX. It must be written only while
// the core is idle.
`include "error_diffusion_dither_core_defines.svh"

module error_diffusion_dither_core #(
  parameter int LINE_MAX  = 1024,
  parameter int FRAC_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  edd_pix_if.sink                           in_pix,
  edd_bit_if.source                         out_bits,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [edd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [edd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [edd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int NUM_CH = edd_pkg::NUM_CH;
  localparam int PIX_W  = edd_pkg::PIX_W;
  localparam int LEN_W  = edd_pkg::LEN_W;
  localparam int ERR_W  = FRAC_BITS + 10;
  localparam int WORD_W = NUM_CH * ERR_W;
  localparam int POS_W  = $clog2(LINE_MAX);
  localparam int CNT_W  = POS_W + 1;
  localparam int CMP_W  = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  // ---------------------------------------------------------------------------
  // Configuration register. pready is tied high, so a write lands at the
  // access cycle.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] line_length_r, line_length_nxt;
  logic             cfg_wr;
  logic             cfg_sel_len;

  assign pready      = 1'b1;
  assign cfg_sel_len = (paddr[2:2] == edd_pkg::REG_LINE_LENGTH);
  assign cfg_wr      = psel && penable && pwrite && pready;

  always_comb begin
    line_length_nxt = line_length_r;
    if (cfg_wr && cfg_sel_len) begin
      line_length_nxt = pwdata[LEN_W-1:0];
    end
    prdata = cfg_sel_len ? edd_pkg::CFG_DATA_W'(line_length_r) : '0;
  end

  // ---------------------------------------------------------------------------
  // Position tracking at the input. The clamped position is the error store
  // read address for the item being accepted.
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] len_ext;
  logic [CNT_W-1:0] len_eff, last_idx, pos_ext;
  logic [POS_W-1:0] position_r, position_nxt;
  logic [POS_W-1:0] p_acc;
  logic             last_acc;
  logic             in_acc;

  always_comb begin
    len_ext = CMP_W'(line_length_r);
    if (len_ext < CMP_W'(2)) begin
      len_eff = CNT_W'(2);
    end else if (len_ext > CMP_W'(LINE_MAX)) begin
      len_eff = CNT_W'(LINE_MAX);
    end else begin
      len_eff = len_ext[CNT_W-1:0];
    end
    last_idx = len_eff - CNT_W'(1);
    pos_ext  = CNT_W'(position_r);

    if (in_pix.frame_start) begin
      p_acc    = '0;
      last_acc = 1'b0;
    end else if (pos_ext >= last_idx) begin
      // Also covers a position left past the end after the length was lowered.
      p_acc    = last_idx[POS_W-1:0];
      last_acc = 1'b1;
    end else begin
      p_acc    = position_r;
      last_acc = 1'b0;
    end

    position_nxt = position_r;
    if (in_acc) begin
      position_nxt = last_acc ? '0 : p_acc + POS_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Compute stage: holds the item while the store read completes, runs the
  // lanes, and hands the result to the output register.
  // ---------------------------------------------------------------------------
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r [NUM_CH];
  logic [PIX_W-1:0] pix_in [NUM_CH];
  logic [POS_W-1:0] s1_p_r;
  logic             s1_last_r;
  logic             s1_fs_r;
  logic             s1_fire;
  logic             in_ready;
  logic             out_valid_r, out_valid_nxt;
  logic [NUM_CH-1:0] out_bits_r;
  logic             out_line_end_r;

  assign pix_in[0] = in_pix.red_in;
  assign pix_in[1] = in_pix.green_in;
  assign pix_in[2] = in_pix.blue_in;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_bits.ready);
  assign in_ready     = !s1_valid_r || s1_fire;
  assign in_acc       = in_pix.valid && in_ready;
  assign in_pix.ready = in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_bits.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Line error store with its write arbitration, bypass and fill count.
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic              a_we;
  logic [WORD_W-1:0] a_word, here_word;
  logic              b_pend_r, b_pend_nxt;
  logic [POS_W-1:0]  b_addr_r;
  logic [WORD_W-1:0] b_data_r;
  logic              byp_hit_r, byp_hit_nxt;
  logic [WORD_W-1:0] byp_data_r, byp_data_nxt;
  logic [WORD_W-1:0] rd_word;
  logic [CNT_W-1:0]  fill_r, fill_nxt, fill_base, fill_top;
  logic              entry_ok;

  edd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LINE_MAX)
  ) u_err_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (p_acc),
    .rdata (ram_rdata)
  );

  // The 3/16 share goes one entry back; the deferred write only ever meets
  // a first-of-line pixel, which writes nothing, so the port never collides.
  assign a_we = s1_fire && (s1_p_r != '0);

  always_comb begin
    if (a_we) begin
      ram_waddr = s1_p_r - POS_W'(1);
      ram_wdata = a_word;
    end else begin
      ram_waddr = b_addr_r;
      ram_wdata = b_data_r;
    end
    ram_we = a_we || b_pend_r;

    b_pend_nxt = s1_fire && s1_last_r;

    byp_hit_nxt  = byp_hit_r;
    byp_data_nxt = byp_data_r;
    if (in_acc) begin
      byp_hit_nxt  = ram_we && (ram_waddr == p_acc);
      byp_data_nxt = ram_wdata;
    end else if (s1_valid_r && ram_we && (ram_waddr == s1_p_r)) begin
      byp_hit_nxt  = 1'b1;
      byp_data_nxt = ram_wdata;
    end

    rd_word  = byp_hit_r ? byp_data_r : ram_rdata;
    entry_ok = !s1_fs_r && (CNT_W'(s1_p_r) < fill_r);

    // Entries written this frame always form a prefix of the store.
    fill_base = s1_fs_r ? '0 : fill_r;
    fill_top  = CNT_W'(s1_p_r) + (s1_last_r ? CNT_W'(1) : CNT_W'(0));
    fill_nxt  = fill_r;
    if (s1_fire) begin
      fill_nxt = (fill_top > fill_base) ? fill_top : fill_base;
    end
  end

  // ---------------------------------------------------------------------------
  // Color lanes and the merge of their results.
  // ---------------------------------------------------------------------------
  edd_pkg::lane_ctl_t      lane_ctl;
  logic signed [ERR_W-1:0] mem_err   [NUM_CH];
  logic signed [ERR_W-1:0] lane_left [NUM_CH];
  logic signed [ERR_W-1:0] lane_here [NUM_CH];
  logic [NUM_CH-1:0]       lane_bit;

  assign lane_ctl.fire        = s1_fire;
  assign lane_ctl.frame_start = s1_fs_r;
  assign lane_ctl.last        = s1_last_r;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    assign mem_err[c] = entry_ok ? signed'(rd_word[c*ERR_W +: ERR_W]) : '0;

    edd_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .value    (s1_pix_r[c]),
      .mem_err  (mem_err[c]),
      .bit_o    (lane_bit[c]),
      .left_err (lane_left[c]),
      .here_err (lane_here[c])
    );

    assign a_word[c*ERR_W +: ERR_W]    = lane_left[c];
    assign here_word[c*ERR_W +: ERR_W] = lane_here[c];
  end

  assign out_bits.valid     = out_valid_r;
  assign out_bits.red_bit   = out_bits_r[0];
  assign out_bits.green_bit = out_bits_r[1];
  assign out_bits.blue_bit  = out_bits_r[2];
  assign out_bits.line_end  = out_line_end_r;

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= edd_pkg::LEN_RESET;
      position_r    <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      b_pend_r      <= 1'b0;
      byp_hit_r     <= 1'b0;
      fill_r        <= '0;
    end else begin
      line_length_r <= line_length_nxt;
      position_r    <= position_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      b_pend_r      <= b_pend_nxt;
      byp_hit_r     <= byp_hit_nxt;
      fill_r        <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= byp_data_nxt;
    if (in_acc) begin
      s1_pix_r  <= pix_in;
      s1_p_r    <= p_acc;
      s1_last_r <= last_acc;
      s1_fs_r   <= in_pix.frame_start;
    end
    if (s1_fire) begin
      out_bits_r     <= lane_bit;
      out_line_end_r <= s1_last_r;
    end
    if (b_pend_nxt) begin
      b_addr_r <= s1_p_r;
      b_data_r <= here_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `EDD_ASSERT_IMPL(a_single_write, a_we, !b_pend_r, "two error store writes in one cycle")
  `EDD_ASSERT_NEXT(a_pend_one_cycle, b_pend_r, !b_pend_r, "deferred store write held over")
  `EDD_ASSERT_IMPL(a_no_bubble, (!out_valid_r || out_bits.ready), in_pix.ready, "input held off")
  `EDD_ASSERT_IMPL(a_fill_bound, s1_valid_r, (fill_r <= CNT_W'(LINE_MAX)), "fill count too large")

endmodule
